[hw/rtl/pps_pkg.sv]
// Shared widths and record types of the preemptive priority scheduler.
`timescale 1ns / 1ps
`default_nettype none
package pps_pkg;

  localparam int ID_W    = 16;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 12;
  localparam int PRI_W   = 8;
  localparam int RES_W   = 17;
  localparam int TOT_W   = 21;

  // One process record as held in the slot memories.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   prio;
    logic [BURST_W-1:0] remaining;
  } entry_t;

  // Outcome of one pass over the loaded slots.
  typedef struct packed {
    logic             have_best;
    entry_t           best;
    logic             have_next;
    logic [ARR_W-1:0] next_arr;
  } scan_t;

endpackage
`default_nettype wire

[hw/rtl/preemptive_priority_scheduler.sv]
// Top level of the preemptive priority scheduler: load sequencer, time keeping and results.
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------------
//  record    start high, busy low      process_id arrival_time burst_time
//                                      priority_req last_process
//  result    result_strobe, 1 cycle    done_id finish_time waiting_time
//                                      turnaround_time total_waiting total_turnaround
//                                      last_result
//
// A record without the last mark is stored and busy stays low.
// After the last record, each scheduling step is one pass over the n loaded
// slots through the single slot read port, plus the finish state to form a
// result when a process completes. Idle gaps and preemptions each cost one
// extra pass. Reset is synchronous and clears the sequencer and counts;
// the slot memories hold garbage until loaded. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module preemptive_priority_scheduler #(
  parameter int PROCESS_SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [pps_pkg::ID_W-1:0]    process_id,
  input  logic [pps_pkg::ARR_W-1:0]   arrival_time,
  input  logic [pps_pkg::BURST_W-1:0] burst_time,
  input  logic [pps_pkg::PRI_W-1:0]   priority_req,
  input  logic                        last_process,
  output logic                        result_strobe,
  output logic [pps_pkg::ID_W-1:0]    done_id,
  output logic [pps_pkg::RES_W-1:0]   finish_time,
  output logic [pps_pkg::RES_W-1:0]   waiting_time,
  output logic [pps_pkg::RES_W-1:0]   turnaround_time,
  output logic [pps_pkg::TOT_W-1:0]   total_waiting,
  output logic [pps_pkg::TOT_W-1:0]   total_turnaround,
  output logic                        last_result
);
  import pps_pkg::*;

  localparam int IDX_W  = $clog2(PROCESS_SLOTS);
  localparam int CNT_W  = $clog2(PROCESS_SLOTS + 1);
  // Latest possible completion is the latest arrival plus every burst.
  localparam int TIME_W = $clog2((1 << ARR_W) + PROCESS_SLOTS * (1 << BURST_W));

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0]               state;
  logic [CNT_W-1:0]         loaded_count;
  logic [CNT_W-1:0]         done_count;
  logic [CNT_W-1:0]         issue_cnt;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_idx;
  logic [TIME_W-1:0]        now;
  logic [PROCESS_SLOTS-1:0] finished;
  logic [TOT_W-1:0]         tot_wait;
  logic [TOT_W-1:0]         tot_turn;

  logic              accept;
  logic              load_wr;
  logic              issue;
  logic              scan_last;
  entry_t            wr_entry;
  entry_t            rd_entry;
  scan_t             scan_res;
  logic [IDX_W-1:0]  best_idx;
  logic              rem_wr_en;
  logic [BURST_W-1:0] rem_data;
  logic [TIME_W-1:0] end_t;
  logic [TIME_W-1:0] next_ext;
  logic              preempt;
  logic [TIME_W-1:0] turn;
  logic [TIME_W-1:0] wait_t;
  logic              final_one;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  assign load_wr = accept && (loaded_count < CNT_W'(PROCESS_SLOTS));
  assign issue   = (state == ST_SCAN) && (issue_cnt < loaded_count);
  assign scan_last = rd_vld && (CNT_W'(rd_idx) == (loaded_count - CNT_W'(1)));

  assign wr_entry.id        = process_id;
  assign wr_entry.arrival   = arrival_time;
  assign wr_entry.burst     = burst_time;
  assign wr_entry.prio      = priority_req;
  assign wr_entry.remaining = burst_time;

  assign next_ext = {{(TIME_W-ARR_W){1'b0}}, scan_res.next_arr};
  assign end_t    = now + {{(TIME_W-BURST_W){1'b0}}, scan_res.best.remaining};
  assign preempt  = scan_res.have_next && (next_ext < end_t);
  // What is left of the burst after running up to the next arrival.
  assign rem_data  = BURST_W'(end_t - next_ext);
  assign rem_wr_en = (state == ST_DECIDE) && scan_res.have_best && preempt;

  assign turn      = now - {{(TIME_W-ARR_W){1'b0}}, scan_res.best.arrival};
  assign wait_t    = turn - {{(TIME_W-BURST_W){1'b0}}, scan_res.best.burst};
  assign final_one = ((done_count + CNT_W'(1)) == loaded_count);

  pps_store #(
    .SLOTS (PROCESS_SLOTS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk       (clk),
    .wr_en     (load_wr),
    .wr_addr   (loaded_count[IDX_W-1:0]),
    .wr_entry  (wr_entry),
    .rem_wr_en (rem_wr_en),
    .rem_addr  (best_idx),
    .rem_data  (rem_data),
    .rd_addr   (issue_cnt[IDX_W-1:0]),
    .rd_entry  (rd_entry)
  );

  pps_scan #(
    .IDX_W  (IDX_W),
    .TIME_W (TIME_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .clear    (state != ST_SCAN),
    .rd_vld   (rd_vld),
    .rd_idx   (rd_idx),
    .rd_done  (finished[rd_idx]),
    .rd_entry (rd_entry),
    .now      (now),
    .result   (scan_res),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      loaded_count  <= '0;
      done_count    <= '0;
      issue_cnt     <= '0;
      rd_vld        <= 1'b0;
      now           <= '0;
      finished      <= '0;
      tot_wait      <= '0;
      tot_turn      <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= (state == ST_FINISH);
      rd_vld        <= issue;
      if (issue) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      unique case (state)
        ST_IDLE: begin
          if (load_wr) begin
            loaded_count <= loaded_count + CNT_W'(1);
          end
          if (accept && last_process) begin
            state     <= ST_SCAN;
            issue_cnt <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_last) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          issue_cnt <= '0;
          if (!scan_res.have_best) begin
            now   <= next_ext;
            state <= ST_SCAN;
          end else if (preempt) begin
            now   <= next_ext;
            state <= ST_SCAN;
          end else begin
            now                <= end_t;
            finished[best_idx] <= 1'b1;
            state              <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (final_one) begin
            state        <= ST_IDLE;
            loaded_count <= '0;
            done_count   <= '0;
            now          <= '0;
            finished     <= '0;
            tot_wait     <= '0;
            tot_turn     <= '0;
          end else begin
            state      <= ST_SCAN;
            done_count <= done_count + CNT_W'(1);
            tot_wait   <= tot_wait + TOT_W'(wait_t);
            tot_turn   <= tot_turn + TOT_W'(turn);
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= issue_cnt[IDX_W-1:0];
    if (state == ST_FINISH) begin
      done_id          <= scan_res.best.id;
      finish_time      <= now[RES_W-1:0];
      waiting_time     <= wait_t[RES_W-1:0];
      turnaround_time  <= turn[RES_W-1:0];
      total_waiting    <= tot_wait + TOT_W'(wait_t);
      total_turnaround <= tot_turn + TOT_W'(turn);
      last_result      <= final_one;
    end
  end

`ifndef ASSERT_OFF
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_result) |-> !busy)
    else $error("scheduler still busy during the final result");

  a_last_starts_run: assert property (@(posedge clk) disable iff (rst)
    (accept && last_process) |=> busy)
    else $error("last record did not start the schedule");

  a_done_below_loaded: assert property (@(posedge clk) disable iff (rst)
    busy |-> (done_count < loaded_count))
    else $error("completion count reached the loaded count while busy");

  a_result_from_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result transfer without a running schedule");
`endif

endmodule
`default_nettype wire

[hw/rtl/pps_store.sv]
// Slot memories for the process records, a load write port, a remaining-time write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module pps_store #(
  parameter int SLOTS = 16,
  parameter int IDX_W = 4
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IDX_W-1:0]             wr_addr,
  input  pps_pkg::entry_t              wr_entry,
  input  logic                         rem_wr_en,
  input  logic [IDX_W-1:0]             rem_addr,
  input  logic [pps_pkg::BURST_W-1:0]  rem_data,
  input  logic [IDX_W-1:0]             rd_addr,
  output pps_pkg::entry_t              rd_entry
);
  import pps_pkg::*;

  logic [ID_W-1:0]    id_mem      [SLOTS];
  logic [ARR_W-1:0]   arrival_mem [SLOTS];
  logic [BURST_W-1:0] burst_mem   [SLOTS];
  logic [PRI_W-1:0]   prio_mem    [SLOTS];
  logic [BURST_W-1:0] rem_mem     [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      id_mem[wr_addr]      <= wr_entry.id;
      arrival_mem[wr_addr] <= wr_entry.arrival;
      burst_mem[wr_addr]   <= wr_entry.burst;
      prio_mem[wr_addr]    <= wr_entry.prio;
    end
  end

  // Loading and preemption never happen in the same cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_addr] <= wr_entry.remaining;
    end else if (rem_wr_en) begin
      rem_mem[rem_addr] <= rem_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry.id        <= id_mem[rd_addr];
    rd_entry.arrival   <= arrival_mem[rd_addr];
    rd_entry.burst     <= burst_mem[rd_addr];
    rd_entry.prio      <= prio_mem[rd_addr];
    rd_entry.remaining <= rem_mem[rd_addr];
  end

endmodule
`default_nettype wire

[hw/rtl/pps_scan.sv]
// Compare unit that walks the slots one per cycle, tracking the best ready process and next arrival.
`timescale 1ns / 1ps
`default_nettype none
module pps_scan #(
  parameter int IDX_W  = 4,
  parameter int TIME_W = 17
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              rd_vld,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic              rd_done,
  input  pps_pkg::entry_t   rd_entry,
  input  logic [TIME_W-1:0] now,
  output pps_pkg::scan_t    result,
  output logic [IDX_W-1:0]  best_idx
);
  import pps_pkg::*;

  logic [TIME_W-1:0] arr_ext;
  logic              arrived;
  logic              take_best;
  logic              take_next;

  assign arr_ext = {{(TIME_W-ARR_W){1'b0}}, rd_entry.arrival};
  assign arrived = (arr_ext <= now);

  // Ties on priority go to the earlier arrival; on a full tie the earlier slot stays.
  assign take_best = rd_vld && !rd_done && arrived &&
                     (!result.have_best || (rd_entry.prio > result.best.prio) ||
                      ((rd_entry.prio == result.best.prio) &&
                       (rd_entry.arrival < result.best.arrival)));
  assign take_next = rd_vld && !rd_done && !arrived &&
                     (!result.have_next || (rd_entry.arrival < result.next_arr));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      result.have_best <= 1'b0;
      result.have_next <= 1'b0;
    end else begin
      if (take_best) begin
        result.have_best <= 1'b1;
      end
      if (take_next) begin
        result.have_next <= 1'b1;
      end
    end
    if (take_best) begin
      result.best <= rd_entry;
      best_idx    <= rd_idx;
    end
    if (take_next) begin
      result.next_arr <= rd_entry.arrival;
    end
  end

endmodule
`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the preemptive priority scheduler; it checks random process sets against a scheduling predictor.
module tb_top;
  import pps_pkg::*;

  localparam int SLOTS = 16;
  localparam int ITEMS = 180;
  localparam int QUIET_TAIL = 30;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [ARR_W-1:0]   arrival;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   prio;
    logic               last;
    int                 idle_before;
    bit                 drain_first;
  } record_t;

  typedef struct {
    logic [ID_W-1:0]  id;
    logic [RES_W-1:0] finish;
    logic [RES_W-1:0] waiting;
    logic [RES_W-1:0] turnaround;
    logic [TOT_W-1:0] tot_wait;
    logic [TOT_W-1:0] tot_turn;
    logic             last;
  } completion_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [ID_W-1:0]    process_id = '0;
  logic [ARR_W-1:0]   arrival_time = '0;
  logic [BURST_W-1:0] burst_time = '0;
  logic [PRI_W-1:0]   priority_req = '0;
  logic               last_process = 1'b0;
  logic               result_strobe;
  logic [ID_W-1:0]    done_id;
  logic [RES_W-1:0]   finish_time;
  logic [RES_W-1:0]   waiting_time;
  logic [RES_W-1:0]   turnaround_time;
  logic [TOT_W-1:0]   total_waiting;
  logic [TOT_W-1:0]   total_turnaround;
  logic               last_result;

  record_t     records_pending[$];
  completion_t completions_due[$];
  record_t     on_bus;
  int          idle_left = 0;
  int          generated = 0;
  int          accepted = 0;
  int          sets_built = 0;
  int          overflow_sets = 0;
  int          drains = 0;
  int          checked = 0;
  int          errors = 0;

  // Predictor copy of the slot memories for the set being loaded.
  logic [ID_W-1:0] slot_id[SLOTS];
  int              slot_arr[SLOTS];
  int              slot_burst[SLOTS];
  int              slot_prio[SLOTS];
  int              slot_left[SLOTS];
  int              slot_count = 0;

  preemptive_priority_scheduler #(.PROCESS_SLOTS(SLOTS)) i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .process_id       (process_id),
    .arrival_time     (arrival_time),
    .burst_time       (burst_time),
    .priority_req     (priority_req),
    .last_process     (last_process),
    .result_strobe    (result_strobe),
    .done_id          (done_id),
    .finish_time      (finish_time),
    .waiting_time     (waiting_time),
    .turnaround_time  (turnaround_time),
    .total_waiting    (total_waiting),
    .total_turnaround (total_turnaround),
    .last_result      (last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Runs the loaded set to completion and queues one completion per process.
  function automatic void schedule_set();
    int n, finished, best, now, next_arr, end_t, wait_t, turn_t, tot_w, tot_t;
    bit have_next;
    bit [SLOTS-1:0] retired;
    completion_t c;
    n = slot_count;
    finished = 0;
    now = 0;
    tot_w = 0;
    tot_t = 0;
    retired = '0;
    while (finished < n) begin
      best = -1;
      have_next = 1'b0;
      next_arr = 0;
      for (int i = 0; i < n; i++) begin
        if (retired[i]) continue;
        if (slot_arr[i] <= now) begin
          if (best < 0 || slot_prio[i] > slot_prio[best] ||
              (slot_prio[i] == slot_prio[best] && slot_arr[i] < slot_arr[best])) begin
            best = i;
          end
        end else if (!have_next || slot_arr[i] < next_arr) begin
          next_arr = slot_arr[i];
          have_next = 1'b1;
        end
      end
      if (best < 0) begin
        now = next_arr;
      end else begin
        end_t = now + slot_left[best];
        // Any arrival before the end forces a new decision at that point.
        if (have_next && next_arr < end_t) begin
          slot_left[best] -= next_arr - now;
          now = next_arr;
        end else begin
          now = end_t;
          slot_left[best] = 0;
          retired[best] = 1'b1;
          wait_t = now - slot_arr[best] - slot_burst[best];
          turn_t = wait_t + slot_burst[best];
          tot_w += wait_t;
          tot_t += turn_t;
          c.id = slot_id[best];
          c.finish = RES_W'(now);
          c.waiting = RES_W'(wait_t);
          c.turnaround = RES_W'(turn_t);
          c.tot_wait = TOT_W'(tot_w);
          c.tot_turn = TOT_W'(tot_t);
          c.last = (finished + 1 == n);
          completions_due.push_back(c);
          finished++;
        end
      end
    end
    slot_count = 0;
  endfunction

  function automatic void load_record(record_t r);
    if (slot_count < SLOTS) begin
      slot_id[slot_count] = r.id;
      slot_arr[slot_count] = r.arrival;
      slot_burst[slot_count] = r.burst;
      slot_prio[slot_count] = r.prio;
      slot_left[slot_count] = r.burst;
      slot_count++;
    end
    if (r.last) schedule_set();
  endfunction

  function automatic void add_record(logic [ID_W-1:0] id, int arr, int burst, int prio,
                                     bit last, bit drain);
    record_t r;
    r.id = id;
    r.arrival = ARR_W'(arr);
    r.burst = BURST_W'(burst);
    r.prio = PRI_W'(prio);
    r.last = last;
    r.drain_first = drain;
    r.idle_before = 0;
    // Idle bursts come in stretches, with quiet stretches between and none at the end.
    if (generated < ITEMS - QUIET_TAIL && (generated / 20) % 3 != 2 && $urandom_range(0, 1))
      r.idle_before = $urandom_range(1, 8);
    records_pending.push_back(r);
    generated++;
    if (last) sets_built++;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // Driver: a record is transferred at an edge with start high and busy low.
  always @(posedge clk) begin
    bit fire;
    record_t nxt;
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      fire = start && !busy;
      if (fire) begin
        load_record(on_bus);
        accepted++;
        idle_left = (records_pending.size() != 0) ? records_pending[0].idle_before : 0;
      end
      if (!start || fire) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (records_pending.size() != 0 &&
                     !(records_pending[0].drain_first && completions_due.size() != 0)) begin
          nxt = records_pending.pop_front();
          if (nxt.drain_first) drains++;
          on_bus = nxt;
          process_id <= nxt.id;
          arrival_time <= nxt.arrival;
          burst_time <= nxt.burst;
          priority_req <= nxt.prio;
          last_process <= nxt.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is a result transfer and is compared with the oldest completion due.
  always @(posedge clk) begin
    completion_t want;
    if (!rst && result_strobe) begin
      if (completions_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got id %0d", $time, done_id);
      end else begin
        want = completions_due.pop_front();
        check_field("done_id", want.id, done_id);
        check_field("finish_time", want.finish, finish_time);
        check_field("waiting_time", want.waiting, waiting_time);
        check_field("turnaround_time", want.turnaround, turnaround_time);
        check_field("total_waiting", want.tot_wait, total_waiting);
        check_field("total_turnaround", want.tot_turn, total_turnaround);
        check_field("last_result", want.last, last_result);
        checked++;
      end
    end
  end

  initial begin
    int set_len, base, spread, arr, kind;
    bit wide, first_random;

    // Single record at the top of every field, then one at the bottom with a burst of one.
    add_record(16'hFFFF, 65535, 4095, 255, 1'b1, 1'b0);
    add_record(16'h0000, 0, 1, 0, 1'b1, 1'b0);
    // Preemption by a higher priority, a tie on arrival settled by load order,
    // an equal priority that does not preempt, then an idle gap and a zero burst.
    add_record(16'h4131, 0, 10, 5, 1'b0, 1'b0);
    add_record(16'h4132, 3, 4, 9, 1'b0, 1'b0);
    add_record(16'h4133, 3, 2, 9, 1'b0, 1'b0);
    add_record(16'h4134, 5, 3, 5, 1'b0, 1'b0);
    add_record(16'h4135, 40, 0, 1, 1'b1, 1'b0);
    // A full set at the latest arrival and longest burst; the extra record is
    // dropped but its last mark still starts the run.
    for (int k = 0; k < SLOTS + 1; k++)
      add_record(ID_W'($urandom), 65535, 4095, $urandom_range(0, 255), k == SLOTS, 1'b0);
    overflow_sets++;

    first_random = 1'b1;
    while (generated < ITEMS) begin
      kind = $urandom_range(0, 9);
      set_len = (kind < 7) ? $urandom_range(1, 6) :
                (kind < 9) ? $urandom_range(7, SLOTS) : $urandom_range(SLOTS + 1, SLOTS + 4);
      if (set_len > SLOTS) overflow_sets++;
      base = $urandom_range(0, 65535);
      spread = $urandom_range(0, 1) ? 8 : 40;
      wide = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < set_len; k++) begin
        arr = base + $urandom_range(0, spread);
        if (arr > 65535) arr = 65535;
        add_record(ID_W'($urandom), arr,
                   wide ? $urandom_range(1, 4095) : $urandom_range(1, 12),
                   wide ? $urandom_range(0, 255) : $urandom_range(0, 3),
                   k == set_len - 1,
                   k == 0 && (first_random || $urandom_range(0, 5) == 0));
      end
      first_random = 1'b0;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (accepted < generated) @(posedge clk);
    while (completions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Transferred %0d records in %0d sets, %0d of them past capacity.",
             accepted, sets_built, overflow_sets);
    $display("Checked %0d completions; sender drained the results %0d times; %0d errors.",
             checked, drains, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d of %0d records transferred, %0d completions due.",
             accepted, generated, completions_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[files.f]
hw/rtl/pps_pkg.sv
hw/rtl/pps_store.sv
hw/rtl/pps_scan.sv
hw/rtl/preemptive_priority_scheduler.sv
test/tb_top.sv
